### rtl/asd_pkg.sv
// Package for the accelerometer step detector: field widths, register
// indexes, band codes, controller states and the configuration struct.
// No dependencies.
package asd_pkg;

  // Fixed field widths of the beats, registers and multiplier, and the Q10 shift
  localparam int unsigned AXIS_W   = 16;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned MAG_W    = 16;
  localparam int unsigned BAND_W   = 2;
  localparam int unsigned RATIO_W  = 13;
  localparam int unsigned GAP_W    = 16;
  localparam int unsigned MUL_W    = 16;
  localparam int unsigned PROD_W   = 2 * MUL_W;
  localparam int unsigned Q10_SH   = 10;

  // APB register file
  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned DATA_W   = 32;
  localparam logic [1:0] REG_UPPER = 2'd0;
  localparam logic [1:0] REG_LOWER = 2'd1;
  localparam logic [1:0] REG_GAP   = 2'd2;

  localparam logic [RATIO_W-1:0] UPPER_RESET = 13'd2048;
  localparam logic [RATIO_W-1:0] LOWER_RESET = 13'd102;
  localparam logic [GAP_W-1:0]   GAP_RESET   = 16'd400;

  // Starting contents of every window entry, milli-g
  localparam logic [MAG_W-1:0] WINDOW_INIT = 16'd1000;

  // Deviation classes
  localparam logic [BAND_W-1:0] BAND_SMALL = 2'd0;
  localparam logic [BAND_W-1:0] BAND_STEP  = 2'd1;
  localparam logic [BAND_W-1:0] BAND_LARGE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT_GO,
    ST_ROOT,
    ST_SCALE_HI,
    ST_SCALE_LO,
    ST_DECIDE
  } asd_state_t;

  typedef struct packed {
    logic [RATIO_W-1:0] upper_ratio;
    logic [RATIO_W-1:0] lower_ratio;
    logic [GAP_W-1:0]   min_gap;
  } cfg_t;

endpackage

### rtl/asd_if.sv
// Valid/ready channel interfaces for the sample and result beats.
// Depends on asd_pkg for the field widths.
interface asd_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [asd_pkg::AXIS_W-1:0] accel_x;
  logic signed [asd_pkg::AXIS_W-1:0] accel_y;
  logic signed [asd_pkg::AXIS_W-1:0] accel_z;
  logic [asd_pkg::TIME_W-1:0]        time_ms;

  modport source (output valid, accel_x, accel_y, accel_z, time_ms, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, time_ms, output ready);
endinterface

interface asd_out_if;
  logic                        valid;
  logic                        ready;
  logic                        step_detected;
  logic [asd_pkg::COUNT_W-1:0] step_total;
  logic [asd_pkg::MAG_W-1:0]   magnitude;
  logic [asd_pkg::BAND_W-1:0]  band;

  modport source (output valid, step_detected, step_total, magnitude, band, input ready);
  modport sink   (input valid, step_detected, step_total, magnitude, band, output ready);
endinterface

### rtl/asd_regs.sv
// APB register file holding the two deviation ratios and the step gap.
// Depends on asd_pkg for register indexes, reset values and cfg_t.
module asd_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [asd_pkg::ADDR_W-1:0]  paddr,
  input  logic [asd_pkg::DATA_W-1:0]  pwdata,
  output logic [asd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output asd_pkg::cfg_t               cfg
);

  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Write on the access cycle, ignore indexes beyond the list
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.upper_ratio <= asd_pkg::UPPER_RESET;
      cfg.lower_ratio <= asd_pkg::LOWER_RESET;
      cfg.min_gap     <= asd_pkg::GAP_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        asd_pkg::REG_UPPER: cfg.upper_ratio <= pwdata[asd_pkg::RATIO_W-1:0];
        asd_pkg::REG_LOWER: cfg.lower_ratio <= pwdata[asd_pkg::RATIO_W-1:0];
        asd_pkg::REG_GAP:   cfg.min_gap     <= pwdata[asd_pkg::GAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      asd_pkg::REG_UPPER: prdata = asd_pkg::DATA_W'(cfg.upper_ratio);
      asd_pkg::REG_LOWER: prdata = asd_pkg::DATA_W'(cfg.lower_ratio);
      asd_pkg::REG_GAP:   prdata = asd_pkg::DATA_W'(cfg.min_gap);
      default:            prdata = '0;
    endcase
  end

endmodule

### rtl/asd_isqrt.sv
// Digit-serial integer square root: two radicand bits per cycle,
// one root bit per cycle. No package dependencies.
module asd_isqrt #(
  parameter int unsigned RW = 17
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [2*RW-1:0] radicand,
  output logic            busy,
  output logic [RW-1:0]   root
);

  localparam int unsigned CNT_W = $clog2(RW + 1);

  logic [2*RW-1:0]  rad;
  logic [RW:0]      rem;
  logic [CNT_W-1:0] cnt;
  logic [RW+2:0]    rem_sh;
  logic [RW+2:0]    trial;
  logic             fits;

  // Bring down the next radicand digit and try the next root bit
  assign rem_sh = {rem, rad[2*RW-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(RW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad <= {rad[2*RW-3:0], 2'b00};
      if (fits) begin
        rem  <= (RW+1)'(rem_sh - trial);
        root <= {root[RW-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[RW:0];
        root <= {root[RW-2:0], 1'b0};
      end
    end
  end

endmodule

### rtl/asd_cdiv.sv
// Bit-serial restoring divider by a fixed divisor, one quotient bit
// per cycle; forms the window mean. No package dependencies.
module asd_cdiv #(
  parameter int unsigned NUM_W   = 20,
  parameter int unsigned DIVISOR = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  output logic             busy,
  output logic [NUM_W-1:0] quotient
);

  localparam int unsigned REM_W = $clog2(DIVISOR) + 1;
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [REM_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic [REM_W:0]   rem_sh;
  logic             fits;

  // Shift in the next dividend bit; quotient bits fill from the bottom
  assign rem_sh = {rem, quotient[NUM_W-1]};
  assign fits   = rem_sh >= (REM_W+1)'(DIVISOR);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NUM_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= REM_W'(rem_sh - (REM_W+1)'(DIVISOR));
      end else begin
        rem <= rem_sh[REM_W-1:0];
      end
      quotient <= {quotient[NUM_W-2:0], fits};
    end
  end

endmodule

### rtl/accel_step_detector_top.sv
// Flow: IDLE takes the sample beat and starts the mean divider, SQUARE sums the
// squares, ROOT_GO starts the bit-serial root, ROOT waits for root and divider,
// SCALE_HI and SCALE_LO make the ratio compares, DECIDE loads the result beat.
// One sample in flight; a waiting result stalls the next sample beat.
// Reset: synchronous; clears the controller, window valid bits (entries read as
// 1000), sum, slot, step state and output valid; data registers are not reset.
module accel_step_detector_top #(
  parameter int unsigned WINDOW      = 10,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  asd_in_if.sink                      sample,
  asd_out_if.source                   result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [asd_pkg::ADDR_W-1:0]  paddr,
  input  logic [asd_pkg::DATA_W-1:0]  pwdata,
  output logic [asd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  localparam int unsigned RW     = SAMPLE_BITS + 1;
  localparam int unsigned RAD_W  = 2 * RW;
  localparam int unsigned SLOT_W = $clog2(WINDOW);
  localparam int unsigned SUM_W  = asd_pkg::MAG_W + SLOT_W;
  localparam int unsigned CMP_W  = asd_pkg::PROD_W;

  asd_pkg::cfg_t      cfg;
  asd_pkg::asd_state_t state, state_next;

  // Sample capture
  logic [asd_pkg::AXIS_W-1:0] ax_r, ay_r, az_r;
  logic [asd_pkg::TIME_W-1:0] time_r;
  logic                       accept;
  logic                       in_ready_c;
  logic                       div_start, root_start, load;

  // Squaring and shared multiplier
  logic [1:0]                 sq_idx;
  logic [asd_pkg::AXIS_W-1:0] axis_sel;
  logic [SAMPLE_BITS-1:0]     axis_lo, axis_abs;
  logic [asd_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic [asd_pkg::PROD_W-1:0] prod;
  logic [RAD_W-1:0]           acc;

  // Root, mean and deviation
  logic                       root_busy, div_busy;
  logic [RW-1:0]              root;
  logic [SUM_W-1:0]           quotient;
  logic [asd_pkg::MAG_W-1:0]  mag, mean, dev_c, dev;
  logic [CMP_W-1:0]           scaled;
  logic                       too_large, above_lower;
  logic [asd_pkg::BAND_W-1:0] band_c;

  // Window and step state
  logic [asd_pkg::MAG_W-1:0]  win_mem [WINDOW];
  logic [WINDOW-1:0]          win_valid;
  logic [asd_pkg::MAG_W-1:0]  old_word, old_val;
  logic                       old_valid;
  logic [SUM_W-1:0]           window_sum;
  logic [SLOT_W-1:0]          oldest_slot;
  logic [asd_pkg::TIME_W-1:0] last_step_time, elapsed;
  logic [asd_pkg::COUNT_W-1:0] step_count, step_count_next;
  logic                       hit;

  // Result register
  logic                        out_valid;
  logic                        out_det;
  logic [asd_pkg::COUNT_W-1:0] out_total;
  logic [asd_pkg::MAG_W-1:0]   out_mag;
  logic [asd_pkg::BAND_W-1:0]  out_band;

  asd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  asd_isqrt #(.RW(RW)) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (acc),
    .busy     (root_busy),
    .root     (root)
  );

  asd_cdiv #(.NUM_W(SUM_W), .DIVISOR(WINDOW)) u_cdiv (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (window_sum),
    .busy     (div_busy),
    .quotient (quotient)
  );

  assign accept        = sample.valid && in_ready_c;
  assign sample.ready  = in_ready_c;

  // Controller state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= asd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and strobes
  always_comb begin
    state_next = state;
    in_ready_c = 1'b0;
    div_start  = 1'b0;
    root_start = 1'b0;
    load       = 1'b0;
    unique case (state)
      asd_pkg::ST_IDLE: begin
        in_ready_c = 1'b1;
        if (sample.valid) begin
          div_start  = 1'b1;
          state_next = asd_pkg::ST_SQUARE;
        end
      end
      asd_pkg::ST_SQUARE: begin
        if (sq_idx == 2'd3) begin
          state_next = asd_pkg::ST_ROOT_GO;
        end
      end
      asd_pkg::ST_ROOT_GO: begin
        root_start = 1'b1;
        state_next = asd_pkg::ST_ROOT;
      end
      asd_pkg::ST_ROOT: begin
        if (!root_busy && !div_busy) begin
          state_next = asd_pkg::ST_SCALE_HI;
        end
      end
      asd_pkg::ST_SCALE_HI: state_next = asd_pkg::ST_SCALE_LO;
      asd_pkg::ST_SCALE_LO: state_next = asd_pkg::ST_DECIDE;
      asd_pkg::ST_DECIDE: begin
        if (!out_valid || result.ready) begin
          load       = 1'b1;
          state_next = asd_pkg::ST_IDLE;
        end
      end
      default: state_next = asd_pkg::ST_IDLE;
    endcase
  end

  // Pick the axis to square and take its magnitude in SAMPLE_BITS bits
  always_comb begin
    case (sq_idx)
      2'd0:    axis_sel = ax_r;
      2'd1:    axis_sel = ay_r;
      default: axis_sel = az_r;
    endcase
  end

  assign axis_lo  = axis_sel[SAMPLE_BITS-1:0];
  assign axis_abs = axis_lo[SAMPLE_BITS-1] ? SAMPLE_BITS'(~axis_lo + 1'b1) : axis_lo;

  // Shared multiplier: squares first, then the two ratio products
  always_comb begin
    if (state == asd_pkg::ST_SQUARE) begin
      mul_a = asd_pkg::MUL_W'(axis_abs);
      mul_b = asd_pkg::MUL_W'(axis_abs);
    end else if (state == asd_pkg::ST_SCALE_HI) begin
      mul_a = asd_pkg::MUL_W'(cfg.upper_ratio);
      mul_b = mean;
    end else begin
      mul_a = asd_pkg::MUL_W'(cfg.lower_ratio);
      mul_b = mean;
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Capture the beat, step through the squares and accumulate them
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_idx <= '0;
    end else if (accept) begin
      sq_idx <= '0;
    end else if (state == asd_pkg::ST_SQUARE) begin
      sq_idx <= sq_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ax_r   <= sample.accel_x;
      ay_r   <= sample.accel_y;
      az_r   <= sample.accel_z;
      time_r <= sample.time_ms;
      acc    <= '0;
    end else if (state == asd_pkg::ST_SQUARE && sq_idx != 2'd0) begin
      acc <= acc + RAD_W'(prod);
    end
  end

  // Deviation from the mean and the two ratio compares
  assign mag    = asd_pkg::MAG_W'(root);
  assign mean   = asd_pkg::MAG_W'(quotient);
  assign dev_c  = (mag > mean) ? mag - mean : mean - mag;
  assign scaled = CMP_W'({dev, {asd_pkg::Q10_SH{1'b0}}});
  assign above_lower = scaled > prod;

  always_ff @(posedge clk) begin
    if (state == asd_pkg::ST_SCALE_HI) begin
      dev <= dev_c;
    end
    if (state == asd_pkg::ST_SCALE_LO) begin
      too_large <= scaled > prod;
    end
  end

  always_comb begin
    if (too_large) begin
      band_c = asd_pkg::BAND_LARGE;
    end else if (above_lower) begin
      band_c = asd_pkg::BAND_STEP;
    end else begin
      band_c = asd_pkg::BAND_SMALL;
    end
  end

  // Step gate on wrapping elapsed time
  assign elapsed         = time_r - last_step_time;
  assign hit             = (band_c == asd_pkg::BAND_STEP) &&
                           (elapsed > asd_pkg::TIME_W'(cfg.min_gap));
  assign step_count_next = hit ? step_count + 1'b1 : step_count;

  // Window memory: read the oldest entry at the beat, overwrite it at load
  always_ff @(posedge clk) begin
    if (accept) begin
      old_word <= win_mem[oldest_slot];
    end
    if (load) begin
      win_mem[oldest_slot] <= mag;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      old_valid <= win_valid[oldest_slot];
    end
  end

  assign old_val = old_valid ? old_word : asd_pkg::WINDOW_INIT;

  // Running state, updated once per sample when the result loads
  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid      <= '0;
      window_sum     <= SUM_W'(WINDOW * asd_pkg::WINDOW_INIT);
      oldest_slot    <= '0;
      last_step_time <= '0;
      step_count     <= '0;
    end else if (load) begin
      win_valid[oldest_slot] <= 1'b1;
      window_sum <= window_sum - SUM_W'(old_val) + SUM_W'(mag);
      if (oldest_slot == SLOT_W'(WINDOW - 1)) begin
        oldest_slot <= '0;
      end else begin
        oldest_slot <= oldest_slot + 1'b1;
      end
      if (hit) begin
        last_step_time <= time_r;
      end
      step_count <= step_count_next;
    end
  end

  // Output register: hold the beat until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_det   <= hit;
      out_total <= step_count_next;
      out_mag   <= mag;
      out_band  <= band_c;
    end
  end

  assign result.valid         = out_valid;
  assign result.step_detected = out_det;
  assign result.step_total    = out_total;
  assign result.magnitude     = out_mag;
  assign result.band          = out_band;

endmodule

### rtl/asd_check.sv
// Port-level checks on the step detector's channels, bound to the top.
// Depends on asd_pkg for band codes and on accel_step_detector_top.
module asd_check (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        step_detected,
  input logic [asd_pkg::COUNT_W-1:0] step_total,
  input logic [asd_pkg::MAG_W-1:0]   magnitude,
  input logic [asd_pkg::BAND_W-1:0]  band
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid &&
      $stable({step_detected, step_total, magnitude, band}))
    else $error("result beat dropped or changed while stalled");

  // One sample in flight: no beat right after a taken beat
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second sample taken while one is in flight");

  // A counted step lies in the step band
  a_step_band: assert property (@(posedge clk) disable iff (rst)
    out_valid && step_detected |-> band == asd_pkg::BAND_STEP)
    else $error("step counted outside the step band");

  // Band code three and roots above the largest possible never appear
  a_band_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> band != 2'd3 && magnitude <= 16'd56755)
    else $error("result beat out of range");

endmodule

bind accel_step_detector_top asd_check u_asd_check (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (sample.valid),
  .in_ready      (sample.ready),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .step_detected (result.step_detected),
  .step_total    (result.step_total),
  .magnitude     (result.magnitude),
  .band          (result.band)
);

### dv/tb_accel_step_detector_top.sv
// Testbench for accel_step_detector_top: random and directed sample beats,
// a scoreboard with its own step predictor, APB register writes between phases.
// Depends on asd_pkg, asd_in_if/asd_out_if and the top-level RTL.
module tb_accel_step_detector_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WIN_DEPTH      = 10;
  localparam int unsigned SAMPLE_W       = 16;
  localparam int unsigned CLK_PERIOD     = 20;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned STEP_RUN_ITEMS = 100;
  localparam int unsigned PHASE_ITEMS    = 150;
  localparam int unsigned PHASE_COUNT    = 6;
  localparam longint unsigned RUN_LIMIT_NS = 64'd10_000_000;

  // Address slot past the last register; writes there must be ignored
  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef struct {
    logic                        step_detected;
    logic [asd_pkg::COUNT_W-1:0] step_total;
    logic [asd_pkg::MAG_W-1:0]   magnitude;
    logic [asd_pkg::BAND_W-1:0]  band;
  } step_result_t;

  // Scoreboard: tracks window and step state, queues expected result beats
  class step_tracker;
    logic [asd_pkg::RATIO_W-1:0] upper_ratio;
    logic [asd_pkg::RATIO_W-1:0] lower_ratio;
    logic [asd_pkg::GAP_W-1:0]   min_gap;
    logic [asd_pkg::MAG_W-1:0]   recent_mags [WIN_DEPTH];
    logic [19:0]                 mag_sum;
    int unsigned                 next_slot;
    logic [asd_pkg::TIME_W-1:0]  last_step_ms;
    logic [asd_pkg::COUNT_W-1:0] steps;
    step_result_t                pending_results [$];
    int unsigned                 error_count;

    function new();
      upper_ratio  = asd_pkg::UPPER_RESET;
      lower_ratio  = asd_pkg::LOWER_RESET;
      min_gap      = asd_pkg::GAP_RESET;
      foreach (recent_mags[i]) recent_mags[i] = asd_pkg::WINDOW_INIT;
      mag_sum      = 20'(WIN_DEPTH * asd_pkg::WINDOW_INIT);
      next_slot    = 0;
      last_step_ms = '0;
      steps        = '0;
      error_count  = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [asd_pkg::DATA_W-1:0] word);
      case (idx)
        asd_pkg::REG_UPPER: upper_ratio = word[asd_pkg::RATIO_W-1:0];
        asd_pkg::REG_LOWER: lower_ratio = word[asd_pkg::RATIO_W-1:0];
        asd_pkg::REG_GAP:   min_gap     = word[asd_pkg::GAP_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [16:0] axis_size(logic signed [asd_pkg::AXIS_W-1:0] a);
      logic [16:0] v;
      v = {a[asd_pkg::AXIS_W-1], a};
      if (a[asd_pkg::AXIS_W-1]) v = -v;
      return v;
    endfunction

    // Bit-pair integer square root, floor
    function logic [asd_pkg::MAG_W-1:0] root_floor(logic [63:0] n);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] probe;
      rem   = n;
      res   = '0;
      probe = 64'd1 << 62;
      while (probe > rem) probe = probe >> 2;
      while (probe != 0) begin
        if (rem >= res + probe) begin
          rem = rem - (res + probe);
          res = (res >> 1) + probe;
        end else begin
          res = res >> 1;
        end
        probe = probe >> 2;
      end
      return res[asd_pkg::MAG_W-1:0];
    endfunction

    // Predict the result beat of one accepted sample beat
    function void take_sample(logic signed [asd_pkg::AXIS_W-1:0] x,
                              logic signed [asd_pkg::AXIS_W-1:0] y,
                              logic signed [asd_pkg::AXIS_W-1:0] z,
                              logic [asd_pkg::TIME_W-1:0] now);
      logic [63:0]                ax, ay, az;
      logic [asd_pkg::MAG_W-1:0]  mag;
      logic [19:0]                mag_w;
      logic [19:0]                mean;
      logic [63:0]                dev;
      logic [63:0]                scaled;
      logic [asd_pkg::TIME_W-1:0] elapsed;
      step_result_t               res;
      ax      = {47'b0, axis_size(x)};
      ay      = {47'b0, axis_size(y)};
      az      = {47'b0, axis_size(z)};
      mag     = root_floor(ax * ax + ay * ay + az * az);
      mag_w   = 20'(mag);
      mean    = 20'(mag_sum / WIN_DEPTH);
      dev     = (mag_w > mean) ? 64'(mag_w - mean) : 64'(mean - mag_w);
      scaled  = dev * 64'd1024;
      if (scaled > 64'(upper_ratio) * 64'(mean)) res.band = asd_pkg::BAND_LARGE;
      else if (scaled > 64'(lower_ratio) * 64'(mean)) res.band = asd_pkg::BAND_STEP;
      else res.band = asd_pkg::BAND_SMALL;
      // Count a step only after the gap has strictly passed, wrapping time
      elapsed = now - last_step_ms;
      res.step_detected = 1'b0;
      if (res.band == asd_pkg::BAND_STEP && elapsed > {16'b0, min_gap}) begin
        steps             = steps + 16'd1;
        last_step_ms      = now;
        res.step_detected = 1'b1;
      end
      res.step_total = steps;
      res.magnitude  = mag;
      // Replace the oldest window entry
      mag_sum                = mag_sum - 20'(recent_mags[next_slot]) + mag_w;
      recent_mags[next_slot] = mag;
      next_slot              = (next_slot + 1) % WIN_DEPTH;
      pending_results.push_back(res);
    endfunction

    function void match_result(step_result_t act);
      step_result_t want;
      if (pending_results.size() == 0) begin
        $error("result beat with no sample waiting");
        error_count++;
        return;
      end
      want = pending_results.pop_front();
      if (act.step_detected !== want.step_detected) begin
        $error("step_detected: expected %0d, got %0d", want.step_detected,
               act.step_detected);
        error_count++;
      end
      if (act.step_total !== want.step_total) begin
        $error("step_total: expected %0d, got %0d", want.step_total, act.step_total);
        error_count++;
      end
      if (act.magnitude !== want.magnitude) begin
        $error("magnitude: expected %0d, got %0d", want.magnitude, act.magnitude);
        error_count++;
      end
      if (act.band !== want.band) begin
        $error("band: expected %0d, got %0d", want.band, act.band);
        error_count++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [asd_pkg::ADDR_W-1:0] paddr;
  logic [asd_pkg::DATA_W-1:0] pwdata;
  logic [asd_pkg::DATA_W-1:0] prdata;
  logic pready;

  asd_in_if  sample_if ();
  asd_out_if result_if ();

  step_tracker tracker = new();
  bit          idle_on  = 1'b1;
  bit          hold_req = 1'b0;

  accel_step_detector_top #(
    .WINDOW      (WIN_DEPTH),
    .SAMPLE_BITS (SAMPLE_W)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample_if),
    .result  (result_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Offer one sample beat, after a random gap when idling is on, and hold it until accepted
  task automatic send_sample(input logic signed [asd_pkg::AXIS_W-1:0] x,
                             input logic signed [asd_pkg::AXIS_W-1:0] y,
                             input logic signed [asd_pkg::AXIS_W-1:0] z,
                             input logic [asd_pkg::TIME_W-1:0] now);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      sample_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_if.valid   <= 1'b1;
    sample_if.accel_x <= x;
    sample_if.accel_y <= y;
    sample_if.accel_z <= z;
    sample_if.time_ms <= now;
    do @(posedge clk); while (!sample_if.ready);
    tracker.take_sample(x, y, z, now);
  endtask

  // Drop valid and wait for every expected result beat
  task automatic settle_block();
    sample_if.valid <= 1'b0;
    do @(posedge clk); while (tracker.pending_results.size() != 0);
  endtask

  // APB write with random upper bits above the register field
  task automatic apb_write(input logic [1:0] idx, input logic [asd_pkg::DATA_W-1:0] field);
    logic [asd_pkg::DATA_W-1:0] word;
    logic [asd_pkg::DATA_W-1:0] keep;
    keep = (idx == asd_pkg::REG_GAP) ? 32'h0000_FFFF : 32'h0000_1FFF;
    word = $urandom;
    if (idx != REG_SPARE) word = (word & ~keep) | (field & keep);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.write_reg(idx, word);
    @(posedge clk);
  endtask

  // Result side: random stalls, one long hold-off on request, check each beat
  initial begin
    int unsigned  stall;
    step_result_t act;
    result_if.ready <= 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        result_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_on) begin
        stall = $urandom_range(0, 11);
        if (stall != 0) begin
          result_if.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      result_if.ready <= 1'b1;
      do @(posedge clk); while (!result_if.valid);
      act.step_detected = result_if.step_detected;
      act.step_total    = result_if.step_total;
      act.magnitude     = result_if.magnitude;
      act.band          = result_if.band;
      tracker.match_result(act);
    end
  end

  // Stimulus
  initial begin
    logic [asd_pkg::TIME_W-1:0]  clock_ms;
    int                          lanes [3];
    int                          mag_goal;
    logic [asd_pkg::RATIO_W-1:0] upper_val;
    logic [asd_pkg::RATIO_W-1:0] lower_val;
    logic [asd_pkg::GAP_W-1:0]   gap_val;

    rst               <= 1'b1;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    sample_if.valid   <= 1'b0;
    sample_if.accel_x <= '0;
    sample_if.accel_y <= '0;
    sample_if.accel_z <= '0;
    sample_if.time_ms <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: spare address, axis extremes, time wrap, zero mean
    apb_write(REG_SPARE, '0);
    send_sample(16'sd0, 16'sd0, 16'sd0, 32'd500);
    send_sample(16'sd1000, 16'sd0, 16'sd0, 32'd600);
    send_sample(16'sd32767, 16'sd32767, 16'sd32767, 32'd700);
    send_sample(-16'sd32768, -16'sd32768, -16'sd32768, 32'd900);
    send_sample(-16'sd32768, 16'sd32767, -16'sd1, 32'd1000);
    send_sample(16'sd0, -16'sd1100, 16'sd0, 32'hFFFF_FF00);
    send_sample(16'sd0, 16'sd0, 16'sd1200, 32'h0000_0050);
    send_sample(-16'sd1250, 16'sd0, 16'sd0, 32'h0000_0200);
    send_sample(16'sd1, -16'sd1, 16'sd1, 32'hFFFF_FFFF);
    clock_ms = 32'd2000;
    repeat (WIN_DEPTH + 1) begin
      clock_ms = clock_ms + 32'd1000;
      send_sample(16'sd0, 16'sd0, 16'sd0, clock_ms);
    end
    send_sample(16'sd0, 16'sd0, 16'sd1, clock_ms + 32'd1000);
    send_sample(16'sd0, 16'sd0, 16'sd0, clock_ms + 32'd2000);
    settle_block();

    // Step run: ratios set to favour the step band, no gap, no idling
    apb_write(asd_pkg::REG_UPPER, 32'd8191);
    apb_write(asd_pkg::REG_LOWER, 32'd0);
    apb_write(asd_pkg::REG_GAP, 32'd0);
    idle_on = 1'b0;
    for (int n = 0; n < STEP_RUN_ITEMS; n++) begin
      lanes = '{0, 0, 0};
      mag_goal = (n % 2 != 0) ? 1100 : 900;
      if ($urandom_range(0, 1) != 0) mag_goal = -mag_goal;
      lanes[$urandom_range(0, 2)] = mag_goal;
      clock_ms = clock_ms + 32'd1;
      send_sample(16'(lanes[0]), 16'(lanes[1]), 16'(lanes[2]), clock_ms);
    end
    settle_block();

    // Random phases, each under its own register setting
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: begin
          upper_val = asd_pkg::UPPER_RESET;
          lower_val = asd_pkg::LOWER_RESET;
          gap_val   = asd_pkg::GAP_RESET;
        end
        1: begin
          upper_val = 13'd8191;
          lower_val = 13'd0;
          gap_val   = 16'd0;
        end
        2: begin
          upper_val = 13'd0;
          lower_val = 13'd8191;
          gap_val   = 16'd65535;
        end
        3: begin
          upper_val = asd_pkg::RATIO_W'($urandom_range(0, 1500));
          lower_val = asd_pkg::RATIO_W'(32'(upper_val) + $urandom_range(0, 400));
          gap_val   = asd_pkg::GAP_W'($urandom_range(0, 600));
        end
        4: begin
          upper_val = asd_pkg::RATIO_W'($urandom_range(0, 8191));
          lower_val = asd_pkg::RATIO_W'($urandom_range(0, 8191));
          gap_val   = asd_pkg::GAP_W'($urandom_range(0, 65535));
        end
        default: begin
          upper_val = asd_pkg::RATIO_W'($urandom_range(1024, 4096));
          lower_val = asd_pkg::RATIO_W'($urandom_range(0, 400));
          gap_val   = asd_pkg::GAP_W'($urandom_range(0, 800));
        end
      endcase
      apb_write(asd_pkg::REG_UPPER, 32'(upper_val));
      apb_write(asd_pkg::REG_LOWER, 32'(lower_val));
      apb_write(asd_pkg::REG_GAP, 32'(gap_val));
      if (phase == 1) hold_req = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        idle_on = ((k / 37) % 5) != 4;
        if ($urandom_range(0, 3) != 0) begin
          // Gait-like sample: one dominant axis between 0.1 and 2.5 g, small cross axes
          mag_goal = int'($urandom_range(100, 2500));
          if ($urandom_range(0, 1) != 0) mag_goal = -mag_goal;
          lanes[0] = int'($urandom_range(0, 300)) - 150;
          lanes[1] = int'($urandom_range(0, 300)) - 150;
          lanes[2] = int'($urandom_range(0, 300)) - 150;
          lanes[$urandom_range(0, 2)] = mag_goal;
        end else begin
          lanes[0] = int'($urandom);
          lanes[1] = int'($urandom);
          lanes[2] = int'($urandom);
        end
        if ($urandom_range(0, 15) != 0) clock_ms = clock_ms + $urandom_range(0, 700);
        else clock_ms = $urandom;
        send_sample(16'(lanes[0]), 16'(lanes[1]), 16'(lanes[2]), clock_ms);
      end
      settle_block();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
